// ----- hdl/ucs_pkg.sv -----
// ---------------------------------------------------------------------------
// ucs_pkg
// Shared types, codes and character helpers of the URI component splitter.
// ---------------------------------------------------------------------------
package ucs_pkg;

	// defaults of the top-level parameters
	localparam int MAX_LEN_DEF      = 65536;
	localparam int PREFIX_DEPTH_DEF = 32;
	localparam int AUTH_DEPTH_DEF   = 32;

	// buffer index width and the "no index" mark
	localparam int         IDX_W    = 6;
	localparam logic [5:0] NONE_IDX = 6'd63;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// parser phases
	localparam logic [2:0] PH_PREFIX = 3'd0;
	localparam logic [2:0] PH_SLASH  = 3'd1;
	localparam logic [2:0] PH_AUTH   = 3'd2;
	localparam logic [2:0] PH_PATH   = 3'd3;
	localparam logic [2:0] PH_QUERY  = 3'd4;
	localparam logic [2:0] PH_FRAG   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	// component tags
	localparam logic [2:0] COMP_SCHEME = 3'd0;
	localparam logic [2:0] COMP_USER   = 3'd1;
	localparam logic [2:0] COMP_PASS   = 3'd2;
	localparam logic [2:0] COMP_HOST   = 3'd3;
	localparam logic [2:0] COMP_PATH   = 3'd4;
	localparam logic [2:0] COMP_QUERY  = 3'd5;
	localparam logic [2:0] COMP_FRAG   = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_LONG    = 2'd2;
	localparam logic [1:0] ST_OVF     = 2'd3;

	// scheme flag bit positions
	localparam int SF_VALID  = 0;
	localparam int SF_HTTP   = 1;
	localparam int SF_HTTPS  = 2;
	localparam int SF_SCHEME = 3;

	// buffer select
	localparam logic SRC_PREFIX = 1'b0;
	localparam logic SRC_AUTH   = 1'b1;

	// port constants
	localparam logic [16:0] PORT_MAX   = 17'd65535;
	localparam logic [15:0] PORT_HTTP  = 16'd80;
	localparam logic [15:0] PORT_HTTPS = 16'd443;
	localparam logic [16:0] TERM_COUNT = 17'd7;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// one emit range over a buffer, empty when a >= b
	typedef struct packed {
		logic [5:0] a;
		logic [5:0] b;
		logic [2:0] comp;
	} rng_t;

	// everything one input item causes, in emit order:
	// ranges, first byte, second byte, final result
	typedef struct packed {
		logic        src;
		rng_t [2:0]  rng;
		logic        b0_v;
		logic [7:0]  b0;
		logic [2:0]  c0;
		logic        b1_v;
		logic [7:0]  b1;
		logic [2:0]  c1;
		logic        fin_v;
		logic [1:0]  status;
		logic [15:0] port;
		logic        opaque;
		logic [16:0] req;
	} bundle_t;

	// buffer write from front to back
	typedef struct packed {
		logic       en;
		logic       sel;
		logic [5:0] addr;
		logic [7:0] data;
	} wr_t;

	// queue and back state seen by the front
	typedef struct packed {
		logic busy;
		logic full;
	} qstat_t;

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		logic [7:0] l;
		l = to_lower(c);
		return l >= 8'h61 && l <= 8'h7A;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		return c == CH_SLASH || c == CH_QMARK || c == CH_HASH;
	endfunction

	// letters of "https"
	function automatic logic [7:0] https_char(logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = 8'h68;
			3'd1: r = 8'h74;
			3'd2: r = 8'h74;
			3'd3: r = 8'h70;
			3'd4: r = 8'h73;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/ucs_in_if.sv -----
// ---------------------------------------------------------------------------
// ucs_in_if
// Request channel carrying URI characters.
// ---------------------------------------------------------------------------
interface ucs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
endinterface

// ----- hdl/ucs_out_if.sv -----
// ---------------------------------------------------------------------------
// ucs_out_if
// Result channel carrying tagged characters and the final summary.
// ---------------------------------------------------------------------------
interface ucs_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [2:0]  component;
	logic        byte_valid;
	logic        run_last;
	logic [1:0]  status;
	logic [15:0] port;
	logic        opaque;
	logic [16:0] req_size;

	modport source (output valid, out_byte, component, byte_valid, run_last, status, port,
		opaque, req_size, input ready);
	modport sink   (input valid, out_byte, component, byte_valid, run_last, status, port,
		opaque, req_size, output ready);
endinterface

// ----- hdl/ucs_fifo.sv -----
// ---------------------------------------------------------------------------
// ucs_fifo
// Short queue of request bundles between front and back.
// ---------------------------------------------------------------------------
module ucs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ucs_pkg::bundle_t  wdata,
	input  logic              pop,
	output ucs_pkg::bundle_t  rdata,
	output logic              full,
	output logic              empty
);
	localparam int PW = $clog2(ucs_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(ucs_pkg::QUEUE_DEPTH + 1);

	ucs_pkg::bundle_t ent_q [ucs_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	assign full  = cnt_q == CW'(ucs_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = ent_q[rp_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(ucs_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(ucs_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- hdl/ucs_front.sv -----
// ---------------------------------------------------------------------------
// ucs_front
// Accepts URI characters, tracks phase, scheme and authority marks, writes
// the buffers and posts one bundle of emit work per accepted character that has any.
// ---------------------------------------------------------------------------
module ucs_front #(
	parameter int MAX_LEN      = ucs_pkg::MAX_LEN_DEF,
	parameter int PREFIX_DEPTH = ucs_pkg::PREFIX_DEPTH_DEF,
	parameter int AUTH_DEPTH   = ucs_pkg::AUTH_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ucs_in_if.sink            uri,
	input  ucs_pkg::qstat_t   qstat,
	output logic              push,
	output ucs_pkg::bundle_t  bundle,
	output ucs_pkg::wr_t      wr
);
	localparam int TW = $clog2(MAX_LEN + 1);

	typedef struct packed {
		logic [2:0] ph;
		logic [2:0] comp;
	} body_t;

	typedef struct packed {
		logic       ok;
		logic       pg;
		logic [5:0] ue;
		logic [5:0] ps;
		logic [5:0] pe;
		logic [5:0] h0;
		logic [5:0] h1;
	} res_t;

	// tag a body character and step the phase
	function automatic body_t body(logic [2:0] ph, logic [7:0] c);
		body_t r;
		r.ph = ph;
		r.comp = ucs_pkg::COMP_FRAG;
		if (ph == ucs_pkg::PH_PATH) begin
			if (c == ucs_pkg::CH_QMARK) begin
				r.ph = ucs_pkg::PH_QUERY;
				r.comp = ucs_pkg::COMP_QUERY;
			end else if (c == ucs_pkg::CH_HASH) begin
				r.ph = ucs_pkg::PH_FRAG;
			end else begin
				r.comp = ucs_pkg::COMP_PATH;
			end
		end else if (ph == ucs_pkg::PH_QUERY) begin
			if (c == ucs_pkg::CH_HASH) begin
				r.ph = ucs_pkg::PH_FRAG;
			end else begin
				r.comp = ucs_pkg::COMP_QUERY;
			end
		end
		return r;
	endfunction

	// split the buffered authority into user, password, host and port
	function automatic res_t resolve(logic [5:0] len, logic [5:0] at, logic [5:0] ucol,
		logic [5:0] lcol, logic [5:0] bcl, logic hbr, logic aclc, logic pok,
		logic [2:0] pcnt, logic [16:0] pacc);
		res_t       r;
		logic [5:0] hs;
		logic       brk;
		r = '0;
		r.ok = 1'b1;
		hs = '0;
		brk = 1'b0;
		if (at != ucs_pkg::NONE_IDX) begin
			hs = at + 6'd1;
			if (ucol != ucs_pkg::NONE_IDX && ucol < at) begin
				r.ue = ucol;
				r.ps = ucol + 6'd1;
				r.pe = at;
			end else begin
				r.ue = at;
			end
		end
		r.h0 = hs;
		r.h1 = len;
		if (hs < len && hbr) begin
			if (bcl == ucs_pkg::NONE_IDX || bcl >= len) begin
				r.ok = 1'b0;
			end else begin
				r.h0 = hs + 6'd1;
				r.h1 = bcl;
				if (bcl + 6'd1 < len) begin
					if (!aclc) begin
						r.ok = 1'b0;
					end else begin
						r.pg = 1'b1;
						brk = 1'b1;
					end
				end
			end
		end else if (lcol != ucs_pkg::NONE_IDX && (at == ucs_pkg::NONE_IDX || lcol > at)) begin
			r.h1 = lcol;
			r.pg = 1'b1;
		end
		if (r.pg && !(pok && pcnt != 3'd0 && pacc <= ucs_pkg::PORT_MAX &&
			(!brk || lcol == bcl + 6'd1))) begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	logic [2:0]    phase_q, phase_n;
	logic [5:0]    cnt_q, cnt_n;
	logic [5:0]    at_q, at_n;
	logic [5:0]    lcol_q, lcol_n;
	logic [5:0]    ucol_q, ucol_n;
	logic [5:0]    bcl_q, bcl_n;
	logic          pslash_q, pslash_n;
	logic [3:0]    sf_q, sf_n;
	logic [TW-1:0] total_q, total_n;
	logic [16:0]   csum_q, csum_n;
	logic [16:0]   port_q, port_n;
	logic [1:0]    err_q, err_n;
	logic          hasauth_q, hasauth_n;
	logic [16:0]   pacc_q, pacc_n;
	logic [2:0]    pcnt_q, pcnt_n;
	logic          pok_q, pok_n;
	logic          aclc_q, aclc_n;
	logic          hbr_q, hbr_n;

	logic [7:0]    c;
	logic          accept;
	logic          do_res;
	logic          fin;
	logic          chr_ok;
	body_t         bb;
	res_t          res;
	logic [16:0]   add;
	logic [15:0]   pfin;

	assign c      = uri.in_byte;
	assign accept = uri.valid && uri.ready;

	// hold while the queue is full, or while buffers may still be read
	assign uri.ready = !qstat.full && !((phase_q == ucs_pkg::PH_PREFIX ||
		phase_q == ucs_pkg::PH_AUTH) && qstat.busy);

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		at_n      = at_q;
		lcol_n    = lcol_q;
		ucol_n    = ucol_q;
		bcl_n     = bcl_q;
		pslash_n  = pslash_q;
		sf_n      = sf_q;
		total_n   = total_q;
		csum_n    = csum_q;
		port_n    = port_q;
		err_n     = err_q;
		hasauth_n = hasauth_q;
		pacc_n    = pacc_q;
		pcnt_n    = pcnt_q;
		pok_n     = pok_q;
		aclc_n    = aclc_q;
		hbr_n     = hbr_q;
		bundle    = '0;
		wr        = '0;
		do_res    = 1'b0;
		fin       = 1'b0;
		chr_ok    = 1'b0;
		bb        = '0;
		add       = '0;
		pfin      = '0;

		// feed one character
		if (accept && err_q == ucs_pkg::ST_OK && phase_q != ucs_pkg::PH_DONE) begin
			if (c == ucs_pkg::CH_NUL) begin
				fin = 1'b1;
			end else begin
				total_n = total_q + 1'b1;
				if (total_n >= TW'(MAX_LEN)) begin
					err_n = ucs_pkg::ST_LONG;
				end else begin
					unique case (phase_q)
						ucs_pkg::PH_PREFIX: begin
							if (c == ucs_pkg::CH_COLON) begin
								if (cnt_q == 6'd0 || !sf_q[ucs_pkg::SF_VALID]) begin
									err_n = ucs_pkg::ST_INVALID;
								end else begin
									bundle.src = ucs_pkg::SRC_PREFIX;
									bundle.rng[0] = '{a: 6'd0, b: cnt_q,
										comp: ucs_pkg::COMP_SCHEME};
									sf_n = '0;
									sf_n[ucs_pkg::SF_SCHEME] = 1'b1;
									sf_n[ucs_pkg::SF_HTTP] = sf_q[ucs_pkg::SF_HTTP] &&
										cnt_q == 6'd4;
									sf_n[ucs_pkg::SF_HTTPS] = sf_q[ucs_pkg::SF_HTTPS] &&
										cnt_q == 6'd5;
									cnt_n = '0;
									phase_n = ucs_pkg::PH_SLASH;
									pslash_n = 1'b0;
								end
							end else if (ucs_pkg::is_delim(c)) begin
								sf_n = '0;
								if (cnt_q == 6'd0 && c == ucs_pkg::CH_SLASH) begin
									phase_n = ucs_pkg::PH_SLASH;
									pslash_n = 1'b1;
								end else begin
									bundle.src = ucs_pkg::SRC_PREFIX;
									bundle.rng[0] = '{a: 6'd0, b: cnt_q,
										comp: ucs_pkg::COMP_PATH};
									cnt_n = '0;
									bb = body(ucs_pkg::PH_PATH, c);
									phase_n = bb.ph;
									bundle.b1_v = 1'b1;
									bundle.b1 = c;
									bundle.c1 = bb.comp;
								end
							end else if (cnt_q >= 6'(PREFIX_DEPTH)) begin
								err_n = ucs_pkg::ST_OVF;
							end else begin
								chr_ok = (cnt_q == 6'd0) ? ucs_pkg::is_alpha(c) :
									(ucs_pkg::is_alpha(c) || ucs_pkg::is_digit(c) ||
									c == ucs_pkg::CH_PLUS || c == ucs_pkg::CH_MINUS ||
									c == ucs_pkg::CH_DOT);
								if (!chr_ok) begin
									sf_n[ucs_pkg::SF_VALID] = 1'b0;
								end
								if (!(cnt_q < 6'd4 &&
									ucs_pkg::to_lower(c) == ucs_pkg::https_char(cnt_q[2:0]))) begin
									sf_n[ucs_pkg::SF_HTTP] = 1'b0;
								end
								if (!(cnt_q < 6'd5 &&
									ucs_pkg::to_lower(c) == ucs_pkg::https_char(cnt_q[2:0]))) begin
									sf_n[ucs_pkg::SF_HTTPS] = 1'b0;
								end
								wr = '{en: 1'b1, sel: ucs_pkg::SRC_PREFIX, addr: cnt_q, data: c};
								cnt_n = cnt_q + 6'd1;
							end
						end
						ucs_pkg::PH_SLASH: begin
							if (c == ucs_pkg::CH_SLASH && !pslash_q) begin
								pslash_n = 1'b1;
							end else if (c == ucs_pkg::CH_SLASH) begin
								hasauth_n = 1'b1;
								pslash_n = 1'b0;
								cnt_n = '0;
								at_n = ucs_pkg::NONE_IDX;
								lcol_n = ucs_pkg::NONE_IDX;
								ucol_n = ucs_pkg::NONE_IDX;
								bcl_n = ucs_pkg::NONE_IDX;
								pacc_n = '0;
								pcnt_n = '0;
								pok_n = 1'b1;
								aclc_n = 1'b0;
								hbr_n = 1'b0;
								phase_n = ucs_pkg::PH_AUTH;
							end else begin
								if (pslash_q) begin
									bundle.b0_v = 1'b1;
									bundle.b0 = ucs_pkg::CH_SLASH;
									bundle.c0 = ucs_pkg::COMP_PATH;
								end
								pslash_n = 1'b0;
								bb = body(ucs_pkg::PH_PATH, c);
								phase_n = bb.ph;
								bundle.b1_v = 1'b1;
								bundle.b1 = c;
								bundle.c1 = bb.comp;
							end
						end
						ucs_pkg::PH_AUTH: begin
							if (ucs_pkg::is_delim(c)) begin
								do_res = 1'b1;
							end else if (cnt_q >= 6'(AUTH_DEPTH)) begin
								err_n = ucs_pkg::ST_OVF;
							end else begin
								// track marks of the authority
								if (c == ucs_pkg::CH_AT) begin
									at_n = cnt_q;
									bcl_n = ucs_pkg::NONE_IDX;
								end else if (c == ucs_pkg::CH_COLON) begin
									if (ucol_q == ucs_pkg::NONE_IDX) begin
										ucol_n = cnt_q;
									end
									lcol_n = cnt_q;
								end else if (c == ucs_pkg::CH_RBRK && bcl_q == ucs_pkg::NONE_IDX) begin
									bcl_n = cnt_q;
								end
								// port digits after the last colon
								if (c == ucs_pkg::CH_COLON) begin
									pacc_n = '0;
									pcnt_n = '0;
									pok_n = 1'b1;
								end else if (ucs_pkg::is_digit(c) && pcnt_q < 3'd5) begin
									pacc_n = (pacc_q << 3) + (pacc_q << 1) + 17'(c[3:0]);
									pcnt_n = pcnt_q + 3'd1;
								end else begin
									pok_n = 1'b0;
								end
								// first host character and the one after ']'
								if (c == ucs_pkg::CH_AT) begin
									hbr_n = 1'b0;
								end else if (cnt_q == 6'd0 ||
									(at_q != ucs_pkg::NONE_IDX && at_q + 6'd1 == cnt_q)) begin
									hbr_n = c == ucs_pkg::CH_LBRK;
								end
								if (bcl_q != ucs_pkg::NONE_IDX && cnt_q == bcl_q + 6'd1) begin
									aclc_n = c == ucs_pkg::CH_COLON;
								end
								wr = '{en: 1'b1, sel: ucs_pkg::SRC_AUTH, addr: cnt_q, data: c};
								cnt_n = cnt_q + 6'd1;
							end
						end
						default: begin
							bb = body(phase_q, c);
							phase_n = bb.ph;
							bundle.b1_v = 1'b1;
							bundle.b1 = c;
							bundle.c1 = bb.comp;
						end
					endcase
				end
			end
		end

		res = resolve(cnt_n, at_n, ucol_n, lcol_n, bcl_n, hbr_n, aclc_n, pok_n, pcnt_n, pacc_n);

		// resolve the authority at a delimiter
		if (do_res) begin
			if (!res.ok) begin
				err_n = ucs_pkg::ST_INVALID;
			end else begin
				bundle.src = ucs_pkg::SRC_AUTH;
				bundle.rng[0] = '{a: 6'd0, b: res.ue, comp: ucs_pkg::COMP_USER};
				bundle.rng[1] = '{a: res.ps, b: res.pe, comp: ucs_pkg::COMP_PASS};
				bundle.rng[2] = '{a: res.h0, b: res.h1, comp: ucs_pkg::COMP_HOST};
				if (res.pg) begin
					port_n = pacc_n;
				end
				cnt_n = '0;
				at_n = ucs_pkg::NONE_IDX;
				lcol_n = ucs_pkg::NONE_IDX;
				ucol_n = ucs_pkg::NONE_IDX;
				bcl_n = ucs_pkg::NONE_IDX;
				bb = body(ucs_pkg::PH_PATH, c);
				phase_n = bb.ph;
				bundle.b1_v = 1'b1;
				bundle.b1 = c;
				bundle.c1 = bb.comp;
			end
		end

		// finish the text at a zero byte or at the last character
		if (accept && uri.in_last && err_n == ucs_pkg::ST_OK && phase_n != ucs_pkg::PH_DONE) begin
			fin = 1'b1;
		end
		if (fin) begin
			unique case (phase_n)
				ucs_pkg::PH_PREFIX: begin
					sf_n = '0;
					bundle.src = ucs_pkg::SRC_PREFIX;
					bundle.rng[0] = '{a: 6'd0, b: cnt_n, comp: ucs_pkg::COMP_PATH};
					cnt_n = '0;
				end
				ucs_pkg::PH_SLASH: begin
					if (pslash_n) begin
						bundle.b0_v = 1'b1;
						bundle.b0 = ucs_pkg::CH_SLASH;
						bundle.c0 = ucs_pkg::COMP_PATH;
					end
					pslash_n = 1'b0;
				end
				ucs_pkg::PH_AUTH: begin
					if (!res.ok) begin
						err_n = ucs_pkg::ST_INVALID;
					end else begin
						bundle.src = ucs_pkg::SRC_AUTH;
						bundle.rng[0] = '{a: 6'd0, b: res.ue, comp: ucs_pkg::COMP_USER};
						bundle.rng[1] = '{a: res.ps, b: res.pe, comp: ucs_pkg::COMP_PASS};
						bundle.rng[2] = '{a: res.h0, b: res.h1, comp: ucs_pkg::COMP_HOST};
						if (res.pg) begin
							port_n = pacc_n;
						end
						cnt_n = '0;
					end
				end
				default: begin
					cnt_n = cnt_n;
				end
			endcase
			phase_n = ucs_pkg::PH_DONE;
		end

		// count emitted characters
		add = 17'(bundle.b0_v) + 17'(bundle.b1_v);
		for (int k = 0; k < 3; k++) begin
			if (bundle.rng[k].a < bundle.rng[k].b) begin
				add = add + 17'(bundle.rng[k].b - bundle.rng[k].a);
			end
		end
		csum_n = csum_q + add;

		// final summary, then return to reset state
		if (accept && uri.in_last) begin
			bundle.fin_v = 1'b1;
			bundle.status = err_n;
			if (err_n == ucs_pkg::ST_OK) begin
				pfin = port_n[15:0];
				if (pfin == 16'd0 && sf_n[ucs_pkg::SF_SCHEME]) begin
					if (sf_n[ucs_pkg::SF_HTTP]) begin
						pfin = ucs_pkg::PORT_HTTP;
					end else if (sf_n[ucs_pkg::SF_HTTPS]) begin
						pfin = ucs_pkg::PORT_HTTPS;
					end
				end
				bundle.port = pfin;
				bundle.opaque = !hasauth_n;
				bundle.req = csum_n + ucs_pkg::TERM_COUNT;
			end
			phase_n   = ucs_pkg::PH_PREFIX;
			cnt_n     = '0;
			at_n      = ucs_pkg::NONE_IDX;
			lcol_n    = ucs_pkg::NONE_IDX;
			ucol_n    = ucs_pkg::NONE_IDX;
			bcl_n     = ucs_pkg::NONE_IDX;
			pslash_n  = 1'b0;
			sf_n      = 4'b0111;
			total_n   = '0;
			csum_n    = '0;
			port_n    = '0;
			err_n     = ucs_pkg::ST_OK;
			hasauth_n = 1'b0;
			pacc_n    = '0;
			pcnt_n    = '0;
			pok_n     = 1'b1;
			aclc_n    = 1'b0;
			hbr_n     = 1'b0;
		end

		push = bundle.fin_v || bundle.b0_v || bundle.b1_v ||
			(bundle.rng[0].a < bundle.rng[0].b) || (bundle.rng[1].a < bundle.rng[1].b) ||
			(bundle.rng[2].a < bundle.rng[2].b);
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ucs_pkg::PH_PREFIX;
			cnt_q     <= '0;
			at_q      <= ucs_pkg::NONE_IDX;
			lcol_q    <= ucs_pkg::NONE_IDX;
			ucol_q    <= ucs_pkg::NONE_IDX;
			bcl_q     <= ucs_pkg::NONE_IDX;
			pslash_q  <= 1'b0;
			sf_q      <= 4'b0111;
			total_q   <= '0;
			csum_q    <= '0;
			port_q    <= '0;
			err_q     <= ucs_pkg::ST_OK;
			hasauth_q <= 1'b0;
			pacc_q    <= '0;
			pcnt_q    <= '0;
			pok_q     <= 1'b1;
			aclc_q    <= 1'b0;
			hbr_q     <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			cnt_q     <= cnt_n;
			at_q      <= at_n;
			lcol_q    <= lcol_n;
			ucol_q    <= ucol_n;
			bcl_q     <= bcl_n;
			pslash_q  <= pslash_n;
			sf_q      <= sf_n;
			total_q   <= total_n;
			csum_q    <= csum_n;
			port_q    <= port_n;
			err_q     <= err_n;
			hasauth_q <= hasauth_n;
			pacc_q    <= pacc_n;
			pcnt_q    <= pcnt_n;
			pok_q     <= pok_n;
			aclc_q    <= aclc_n;
			hbr_q     <= hbr_n;
		end
	end
endmodule

// ----- hdl/ucs_back.sv -----
// ---------------------------------------------------------------------------
// ucs_back
// Holds the prefix and authority buffers and walks each bundle, one result
// per cycle unless the output stalls, through a read stage into the output register.
// ---------------------------------------------------------------------------
module ucs_back #(
	parameter int PREFIX_DEPTH = ucs_pkg::PREFIX_DEPTH_DEF,
	parameter int AUTH_DEPTH   = ucs_pkg::AUTH_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  ucs_pkg::bundle_t  q_data,
	output logic              q_pop,
	input  ucs_pkg::wr_t      wr,
	output logic              busy,
	ucs_out_if.source         part
);
	localparam int PAW = $clog2(PREFIX_DEPTH);
	localparam int AAW = $clog2(AUTH_DEPTH);

	// walk positions within a bundle
	localparam logic [2:0] SL_R0  = 3'd0;
	localparam logic [2:0] SL_R2  = 3'd2;
	localparam logic [2:0] SL_B0  = 3'd3;
	localparam logic [2:0] SL_B1  = 3'd4;
	localparam logic [2:0] SL_FIN = 3'd5;

	typedef struct packed {
		logic       found;
		logic [2:0] slot;
		logic [5:0] idx;
	} pos_t;

	function automatic logic slot_valid(ucs_pkg::bundle_t b, logic [2:0] s);
		logic r;
		unique case (s)
			SL_B0:  r = b.b0_v;
			SL_B1:  r = b.b1_v;
			SL_FIN: r = b.fin_v;
			3'd0, 3'd1, 3'd2: r = b.rng[s[1:0]].a < b.rng[s[1:0]].b;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// first non-empty position at or after slot s
	function automatic pos_t first_from(ucs_pkg::bundle_t b, logic [3:0] s);
		pos_t r;
		r = '0;
		for (int k = 0; k <= 5; k++) begin
			if (!r.found && 4'(k) >= s && slot_valid(b, 3'(k))) begin
				r.found = 1'b1;
				r.slot = 3'(k);
				// index only matters for range slots
				r.idx = b.rng[(k <= 2) ? k : 0].a;
			end
		end
		return r;
	endfunction

	logic [7:0]       pre_mem  [PREFIX_DEPTH];
	logic [7:0]       auth_mem [AUTH_DEPTH];

	logic             act_q;
	ucs_pkg::bundle_t cur_q;
	logic [2:0]       slot_q;
	logic [5:0]       idx_q;

	logic             v_s1;
	logic             mem_s1;
	logic             sel_s1;
	logic [7:0]       pre_rd_s1;
	logic [7:0]       auth_rd_s1;
	logic [7:0]       byte_s1;
	logic [2:0]       comp_s1;
	logic             bv_s1;
	logic             last_s1;
	logic [1:0]       status_s1;
	logic [15:0]      port_s1;
	logic             opq_s1;
	logic [16:0]      req_s1;

	logic             out_load;
	logic             issue;
	pos_t             nxt;
	logic             in_rng;

	assign out_load = v_s1 && (!part.valid || part.ready);
	assign issue    = act_q && (!v_s1 || out_load);
	assign q_pop    = !act_q && q_valid;
	assign busy     = act_q || v_s1;
	assign in_rng   = slot_q <= SL_R2;

	// next position after the current one
	always_comb begin
		if (in_rng && idx_q + 6'd1 < cur_q.rng[slot_q[1:0]].b) begin
			nxt = '{found: 1'b1, slot: slot_q, idx: idx_q + 6'd1};
		end else begin
			nxt = first_from(cur_q, 4'(slot_q) + 4'd1);
		end
	end

	// write buffers
	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.sel == ucs_pkg::SRC_AUTH) begin
				auth_mem[wr.addr[AAW-1:0]] <= wr.data;
			end else begin
				pre_mem[wr.addr[PAW-1:0]] <= wr.data;
			end
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			pre_rd_s1  <= pre_mem[idx_q[PAW-1:0]];
			auth_rd_s1 <= auth_mem[idx_q[AAW-1:0]];
			mem_s1     <= in_rng;
			sel_s1     <= cur_q.src;
			last_s1    <= !nxt.found;
			byte_s1    <= '0;
			comp_s1    <= '0;
			bv_s1      <= 1'b1;
			status_s1  <= ucs_pkg::ST_OK;
			port_s1    <= '0;
			opq_s1     <= 1'b0;
			req_s1     <= '0;
			unique case (slot_q)
				SL_B0: begin
					byte_s1 <= cur_q.b0;
					comp_s1 <= cur_q.c0;
				end
				SL_B1: begin
					byte_s1 <= cur_q.b1;
					comp_s1 <= cur_q.c1;
				end
				SL_FIN: begin
					bv_s1     <= 1'b0;
					status_s1 <= cur_q.status;
					port_s1   <= cur_q.port;
					opq_s1    <= cur_q.opaque;
					req_s1    <= cur_q.req;
				end
				default: begin
					comp_s1 <= cur_q.rng[slot_q[1:0]].comp;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			part.out_byte   <= mem_s1 ? (sel_s1 ? auth_rd_s1 : pre_rd_s1) : byte_s1;
			part.component  <= comp_s1;
			part.byte_valid <= bv_s1;
			part.run_last   <= last_s1;
			part.status     <= status_s1;
			part.port       <= port_s1;
			part.opaque     <= opq_s1;
			part.req_size   <= req_s1;
		end
	end

	// walk bundles, advance stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q      <= 1'b0;
			slot_q     <= SL_R0;
			idx_q      <= '0;
			v_s1       <= 1'b0;
			part.valid <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q  <= 1'b1;
				slot_q <= first_from(q_data, 4'd0).slot;
				idx_q  <= first_from(q_data, 4'd0).idx;
			end else if (issue) begin
				act_q  <= nxt.found;
				slot_q <= nxt.slot;
				idx_q  <= nxt.idx;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (out_load) begin
				v_s1 <= 1'b0;
			end
			if (out_load) begin
				part.valid <= 1'b1;
			end else if (part.ready) begin
				part.valid <= 1'b0;
			end
		end
	end

	// hold the bundle being walked
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end
endmodule

// ----- hdl/uri_component_splitter.sv -----
// An accepted request passes the queue, the bundle register, the read stage and the output
// register to its first result, then 1 result per cycle while the output is not stalled.
// The back end pops the next request only after issuing the last result of the current one.
// The first character of a URI and characters buffered for scheme or authority wait
// until the back end has drained the results of earlier requests.
// Reset (arst_n low) clears the parser and queue; buffers hold no reset value.
// ---------------------------------------------------------------------------
// uri_component_splitter
// Splits a URI stream into tagged scheme, userinfo, host, path, query and
// fragment characters and a final status summary.
// ---------------------------------------------------------------------------
module uri_component_splitter #(
	parameter int MAX_LEN      = ucs_pkg::MAX_LEN_DEF,
	parameter int PREFIX_DEPTH = ucs_pkg::PREFIX_DEPTH_DEF,
	parameter int AUTH_DEPTH   = ucs_pkg::AUTH_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ucs_in_if.sink    uri,
	ucs_out_if.source part
);
	ucs_pkg::bundle_t push_data;
	ucs_pkg::bundle_t pop_data;
	ucs_pkg::wr_t     wr;
	ucs_pkg::qstat_t  qstat;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	logic             back_busy;

	assign qstat = '{busy: back_busy || !empty, full: full};

	// classify characters and post work
	ucs_front #(
		.MAX_LEN      (MAX_LEN),
		.PREFIX_DEPTH (PREFIX_DEPTH),
		.AUTH_DEPTH   (AUTH_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.uri    (uri),
		.qstat  (qstat),
		.push   (push),
		.bundle (push_data),
		.wr     (wr)
	);

	// decouple front and back
	ucs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (pop_data),
		.full   (full),
		.empty  (empty)
	);

	// emit results
	ucs_back #(
		.PREFIX_DEPTH (PREFIX_DEPTH),
		.AUTH_DEPTH   (AUTH_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!empty),
		.q_data  (pop_data),
		.q_pop   (pop),
		.wr      (wr),
		.busy    (back_busy),
		.part    (part)
	);
endmodule
